>>> rtl/core/isu_pkg.sv
package isu_pkg;

    localparam int MAX_VERTICES_DEF = 8192;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int IDX_W            = 13;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_SUBDIV = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNWRITTEN = 2'd2,
        ST_ZERO      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQUARE,
        N_SQRT,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DECODE,
        B_RD_WAIT,
        B_NORM_ADD,
        B_CORNER,
        B_MID_START,
        B_MID_WAIT,
        B_WRITE,
        B_EMIT
    } back_state_t;

endpackage

>>> rtl/core/isu_front.sv
module isu_front #(
    parameter int COORD_WIDTH = isu_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    operation,
    input  logic [COORD_WIDTH-1:0]        coord_x,
    input  logic [COORD_WIDTH-1:0]        coord_y,
    input  logic [COORD_WIDTH-1:0]        coord_z,
    input  logic [isu_pkg::IDX_W-1:0]     index_a,
    input  logic [isu_pkg::IDX_W-1:0]     index_b,
    input  logic [isu_pkg::IDX_W-1:0]     index_c,
    output logic                          item_valid,
    output isu_pkg::op_t                  item_op,
    output logic [3*COORD_WIDTH+3*isu_pkg::IDX_W-1:0] item_data,
    input  logic                          item_pop
);

    localparam int PW = 3*COORD_WIDTH + 3*isu_pkg::IDX_W;
    localparam int DEPTH = isu_pkg::QUEUE_DEPTH;
    localparam int PTRW = $clog2(DEPTH);

    isu_pkg::op_t     op_mem [DEPTH];
    logic [PW-1:0]    data_mem [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW:0]    count_reg;
    logic             wr_en;
    logic             rd_en;
    isu_pkg::op_t     op_dec;

    // classify the raw opcode on entry
    always_comb
    begin
        unique case (operation)
            2'd0:    op_dec = isu_pkg::OP_CLEAR;
            2'd1:    op_dec = isu_pkg::OP_ADD;
            2'd2:    op_dec = isu_pkg::OP_SUBDIV;
            default: op_dec = isu_pkg::OP_READ;
        endcase
    end

    assign full       = (count_reg == (PTRW+1)'(DEPTH));
    assign item_valid = (count_reg != '0);
    assign wr_en      = push && !full;
    assign rd_en      = item_pop && item_valid;
    assign item_op    = op_mem[rd_ptr_reg];
    assign item_data  = data_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            op_mem[wr_ptr_reg]   <= op_dec;
            data_mem[wr_ptr_reg] <= {coord_x, coord_y, coord_z, index_a, index_b, index_c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/core/isu_norm.sv
module isu_norm #(
    parameter int COORD_WIDTH = isu_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH:0]   vec_x,
    input  logic signed [COORD_WIDTH:0]   vec_y,
    input  logic signed [COORD_WIDTH:0]   vec_z,
    output logic                          done,
    output logic                          zero,
    output logic [COORD_WIDTH-1:0]        res_x,
    output logic [COORD_WIDTH-1:0]        res_y,
    output logic [COORD_WIDTH-1:0]        res_z
);

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = CW + 1;        // magnitude
    localparam int SW   = 2*CW + 2;      // sum of squares
    localparam int RW   = CW + 1;        // root
    localparam int QW   = CW - 1;        // quotient bits
    localparam int CNTW = $clog2(RW + 1);

    isu_pkg::norm_state_t state_reg, state_next;

    logic [MW-1:0]    mag_reg [3];
    logic             neg_reg [3];
    logic [SW-1:0]    prod_reg;
    logic [SW-1:0]    acc_reg;
    logic [SW-1:0]    rad_reg;
    logic [RW+1:0]    rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [1:0]       comp_reg;
    logic [RW:0]      r_reg;
    logic [QW-1:0]    dvd_reg;
    logic [QW-1:0]    q_reg;
    logic [CW-1:0]    res_reg [3];
    logic             zero_reg;

    logic [MW-1:0]    mag_sel;
    logic [SW-1:0]    prod_w;
    logic [SW-1:0]    sum_w;
    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic             sq_ge;
    logic [RW:0]      r_sh;
    logic             dv_ge;
    logic [QW-1:0]    q_fin;
    logic [MW-1:0]    mag_nx;
    logic [CW-1:0]    q_ext;

    assign mag_sel = (cnt_reg == CNTW'(3)) ? mag_reg[0] : mag_reg[cnt_reg[1:0]];
    assign prod_w  = SW'(mag_sel) * SW'(mag_sel);
    assign sum_w   = acc_reg + prod_reg;

    // one root bit per cycle
    assign rem_sh = {rem_reg[RW-1:0], rad_reg[SW-1:SW-2]};
    assign trial  = {root_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    // one quotient bit per cycle
    assign r_sh  = {r_reg[RW-1:0], dvd_reg[QW-1]};
    assign dv_ge = (r_sh >= {1'b0, root_reg});
    assign q_fin = {q_reg[QW-2:0], dv_ge};
    assign q_ext = {1'b0, q_fin};
    assign mag_nx = (comp_reg == 2'd0) ? mag_reg[1] : mag_reg[2];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isu_pkg::N_IDLE:
                if (start)
                    state_next = isu_pkg::N_SQUARE;
            isu_pkg::N_SQUARE:
                if (cnt_reg == CNTW'(3))
                    state_next = (sum_w == '0) ? isu_pkg::N_DONE : isu_pkg::N_SQRT;
            isu_pkg::N_SQRT:
                if (cnt_reg == CNTW'(RW-1))
                    state_next = isu_pkg::N_DIV;
            isu_pkg::N_DIV:
                if (cnt_reg == CNTW'(QW-1) && comp_reg == 2'd2)
                    state_next = isu_pkg::N_DONE;
            isu_pkg::N_DONE:
                state_next = isu_pkg::N_IDLE;
            default:
                state_next = isu_pkg::N_IDLE;
        endcase
    end

    always_comb
    begin
        done  = (state_reg == isu_pkg::N_DONE);
        zero  = zero_reg;
        res_x = res_reg[0];
        res_y = res_reg[1];
        res_z = res_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= isu_pkg::N_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            isu_pkg::N_IDLE:
            begin
                if (start)
                begin
                    neg_reg[0] <= vec_x[CW];
                    neg_reg[1] <= vec_y[CW];
                    neg_reg[2] <= vec_z[CW];
                    mag_reg[0] <= vec_x[CW] ? MW'(-vec_x) : MW'(vec_x);
                    mag_reg[1] <= vec_y[CW] ? MW'(-vec_y) : MW'(vec_y);
                    mag_reg[2] <= vec_z[CW] ? MW'(-vec_z) : MW'(vec_z);
                    acc_reg    <= '0;
                    cnt_reg    <= '0;
                    zero_reg   <= 1'b0;
                end
            end
            isu_pkg::N_SQUARE:
            begin
                prod_reg <= prod_w;
                if (cnt_reg != '0)
                    acc_reg <= sum_w;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(3))
                begin
                    zero_reg <= (sum_w == '0);
                    rad_reg  <= sum_w;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                end
            end
            isu_pkg::N_SQRT:
            begin
                rad_reg <= {rad_reg[SW-3:0], 2'b00};
                if (sq_ge)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(RW-1))
                begin
                    cnt_reg  <= '0;
                    comp_reg <= 2'd0;
                    r_reg    <= {2'b00, mag_reg[0][MW-1:1]};
                    dvd_reg  <= {mag_reg[0][0], {(QW-1){1'b0}}};
                    q_reg    <= '0;
                end
            end
            isu_pkg::N_DIV:
            begin
                dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
                r_reg   <= dv_ge ? (r_sh - {1'b0, root_reg}) : r_sh;
                q_reg   <= q_fin;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW-1))
                begin
                    res_reg[comp_reg] <= neg_reg[comp_reg] ? -q_ext : q_ext;
                    cnt_reg  <= '0;
                    comp_reg <= comp_reg + 1'b1;
                    r_reg    <= {2'b00, mag_nx[MW-1:1]};
                    dvd_reg  <= {mag_nx[0], {(QW-1){1'b0}}};
                    q_reg    <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/core/isu_outq.sv
module isu_outq #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data
);

    localparam int DEPTH = isu_pkg::QUEUE_DEPTH;
    localparam int PTRW = $clog2(DEPTH);

    logic [WIDTH-1:0] data_mem [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW:0]    count_reg;
    logic             wr_en;
    logic             rd_en;

    assign full    = (count_reg == (PTRW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_en   = wr && !full;
    assign rd_en   = pop && !empty;
    assign rd_data = data_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            data_mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/core/isu_back.sv
module isu_back #(
    parameter int MAX_VERTICES = isu_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = isu_pkg::COORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  isu_pkg::op_t          item_op,
    input  logic [3*COORD_WIDTH+3*isu_pkg::IDX_W-1:0] item_data,
    output logic                  item_pop,
    input  logic                  res_full,
    output logic                  res_push,
    output logic [6*isu_pkg::IDX_W/2+3*COORD_WIDTH+isu_pkg::IDX_W+2:0] res_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int IW   = isu_pkg::IDX_W;
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int VW   = 3 * CW;

    isu_pkg::back_state_t state_reg, state_next;

    logic [VW-1:0]    mem [MAX_VERTICES];
    logic [VW-1:0]    rdata_reg;
    logic [CNTW-1:0]  count_reg;
    isu_pkg::op_t     op_reg;
    isu_pkg::status_t status_reg;
    logic [CW-1:0]    cx_reg, cy_reg, cz_reg;
    logic [IW-1:0]    ia_reg, ib_reg, ic_reg;
    logic [CW-1:0]    vx_reg, vy_reg, vz_reg;
    logic [IW-1:0]    na_reg;
    logic [1:0]       cnt_reg;
    logic [VW-1:0]    corner_reg [3];
    logic [VW-1:0]    mid_reg [3];

    logic             bad_a, bad_b, bad_c, no_room_1, no_room_3;
    logic             norm_start, norm_done, norm_zero;
    logic [CW:0]      nv_x, nv_y, nv_z;
    logic [CW-1:0]    nr_x, nr_y, nr_z;
    logic [VW-1:0]    p_sel, q_sel;
    logic             mem_we, mem_re;
    logic [AW-1:0]    waddr, raddr;
    logic [VW-1:0]    wdata;
    logic             multi;
    logic             emit_end;
    logic [IW-1:0]    nb, nc;
    logic [IW-1:0]    t0, t1, t2;

    assign bad_a     = 32'(ia_reg) >= 32'(count_reg);
    assign bad_b     = 32'(ib_reg) >= 32'(count_reg);
    assign bad_c     = 32'(ic_reg) >= 32'(count_reg);
    assign no_room_1 = 32'(count_reg) >= 32'(MAX_VERTICES);
    assign no_room_3 = 32'(count_reg) + 32'd3 > 32'(MAX_VERTICES);

    // edge e runs from corner e to corner (e+1) mod 3
    always_comb
    begin
        unique case (cnt_reg)
            2'd0:
            begin
                p_sel = corner_reg[0];
                q_sel = corner_reg[1];
            end
            2'd1:
            begin
                p_sel = corner_reg[1];
                q_sel = corner_reg[2];
            end
            default:
            begin
                p_sel = corner_reg[2];
                q_sel = corner_reg[0];
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == isu_pkg::B_MID_START)
        begin
            nv_x = {p_sel[VW-1], p_sel[VW-1:2*CW]} + {q_sel[VW-1], q_sel[VW-1:2*CW]};
            nv_y = {p_sel[2*CW-1], p_sel[2*CW-1:CW]} + {q_sel[2*CW-1], q_sel[2*CW-1:CW]};
            nv_z = {p_sel[CW-1], p_sel[CW-1:0]} + {q_sel[CW-1], q_sel[CW-1:0]};
        end
        else
        begin
            nv_x = {cx_reg[CW-1], cx_reg};
            nv_y = {cy_reg[CW-1], cy_reg};
            nv_z = {cz_reg[CW-1], cz_reg};
        end
    end

    isu_norm #(
        .COORD_WIDTH(CW)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec_x (nv_x),
        .vec_y (nv_y),
        .vec_z (nv_z),
        .done  (norm_done),
        .zero  (norm_zero),
        .res_x (nr_x),
        .res_y (nr_y),
        .res_z (nr_z)
    );

    assign multi    = (op_reg == isu_pkg::OP_SUBDIV) && (status_reg == isu_pkg::ST_OK);
    assign emit_end = !res_full && (!multi || cnt_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isu_pkg::B_IDLE:
                if (item_valid)
                    state_next = isu_pkg::B_DECODE;
            isu_pkg::B_DECODE:
            begin
                unique case (op_reg)
                    isu_pkg::OP_CLEAR:
                        state_next = isu_pkg::B_EMIT;
                    isu_pkg::OP_ADD:
                        state_next = no_room_1 ? isu_pkg::B_EMIT : isu_pkg::B_NORM_ADD;
                    isu_pkg::OP_READ:
                        state_next = bad_a ? isu_pkg::B_EMIT : isu_pkg::B_RD_WAIT;
                    default:
                        state_next = (bad_a || bad_b || bad_c || no_room_3) ?
                                     isu_pkg::B_EMIT : isu_pkg::B_CORNER;
                endcase
            end
            isu_pkg::B_RD_WAIT:
                state_next = isu_pkg::B_EMIT;
            isu_pkg::B_NORM_ADD:
                if (norm_done)
                    state_next = isu_pkg::B_EMIT;
            isu_pkg::B_CORNER:
                if (cnt_reg == 2'd2)
                    state_next = isu_pkg::B_MID_START;
            isu_pkg::B_MID_START:
                state_next = isu_pkg::B_MID_WAIT;
            isu_pkg::B_MID_WAIT:
            begin
                if (norm_done)
                begin
                    if (norm_zero)
                        state_next = isu_pkg::B_EMIT;
                    else if (cnt_reg == 2'd2)
                        state_next = isu_pkg::B_WRITE;
                    else
                        state_next = isu_pkg::B_MID_START;
                end
            end
            isu_pkg::B_WRITE:
                if (cnt_reg == 2'd2)
                    state_next = isu_pkg::B_EMIT;
            isu_pkg::B_EMIT:
                if (emit_end)
                    state_next = isu_pkg::B_IDLE;
            default:
                state_next = isu_pkg::B_IDLE;
        endcase
    end

    assign nb = na_reg + IW'(1);
    assign nc = na_reg + IW'(2);

    always_comb
    begin
        item_pop   = (state_reg == isu_pkg::B_IDLE) && item_valid;
        norm_start = ((state_reg == isu_pkg::B_DECODE) && (op_reg == isu_pkg::OP_ADD)
                      && !no_room_1) || (state_reg == isu_pkg::B_MID_START);
        mem_re     = 1'b0;
        raddr      = AW'(32'(ia_reg));
        mem_we     = 1'b0;
        waddr      = AW'(count_reg);
        wdata      = {nr_x, nr_y, nr_z};
        res_push   = (state_reg == isu_pkg::B_EMIT);
        t0         = '0;
        t1         = '0;
        t2         = '0;

        if (state_reg == isu_pkg::B_DECODE)
            mem_re = ((op_reg == isu_pkg::OP_READ) && !bad_a)
                  || ((op_reg == isu_pkg::OP_SUBDIV) && !(bad_a || bad_b || bad_c || no_room_3));
        if (state_reg == isu_pkg::B_CORNER && cnt_reg != 2'd2)
        begin
            mem_re = 1'b1;
            raddr  = (cnt_reg == 2'd0) ? AW'(32'(ib_reg)) : AW'(32'(ic_reg));
        end
        if (state_reg == isu_pkg::B_NORM_ADD)
            mem_we = norm_done && !norm_zero;
        if (state_reg == isu_pkg::B_WRITE)
        begin
            mem_we = 1'b1;
            waddr  = AW'(count_reg + CNTW'(cnt_reg));
            wdata  = mid_reg[cnt_reg];
        end

        if (multi)
        begin
            unique case (cnt_reg)
                2'd0:
                begin
                    t0 = ia_reg; t1 = na_reg; t2 = nc;
                end
                2'd1:
                begin
                    t0 = ib_reg; t1 = nb; t2 = na_reg;
                end
                2'd2:
                begin
                    t0 = ic_reg; t1 = nc; t2 = nb;
                end
                default:
                begin
                    t0 = na_reg; t1 = nb; t2 = nc;
                end
            endcase
            res_data = {t0, t1, t2, {VW{1'b0}}, na_reg, status_reg, (cnt_reg == 2'd3)};
        end
        else if (status_reg == isu_pkg::ST_OK && op_reg == isu_pkg::OP_ADD)
            res_data = {t0, t1, t2, vx_reg, vy_reg, vz_reg, na_reg, status_reg, 1'b1};
        else if (status_reg == isu_pkg::ST_OK && op_reg == isu_pkg::OP_READ)
            res_data = {t0, t1, t2, vx_reg, vy_reg, vz_reg, {IW{1'b0}}, status_reg, 1'b1};
        else
            res_data = {t0, t1, t2, {VW{1'b0}}, {IW{1'b0}}, status_reg, 1'b1};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isu_pkg::B_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == isu_pkg::B_DECODE && op_reg == isu_pkg::OP_CLEAR)
                count_reg <= '0;
            if (state_reg == isu_pkg::B_NORM_ADD && norm_done && !norm_zero)
                count_reg <= count_reg + 1'b1;
            if (state_reg == isu_pkg::B_WRITE && cnt_reg == 2'd2)
                count_reg <= count_reg + CNTW'(3);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            isu_pkg::B_IDLE:
            begin
                if (item_valid)
                begin
                    op_reg <= item_op;
                    {cx_reg, cy_reg, cz_reg, ia_reg, ib_reg, ic_reg} <= item_data;
                end
                cnt_reg    <= '0;
                status_reg <= isu_pkg::ST_OK;
            end
            isu_pkg::B_DECODE:
            begin
                na_reg <= IW'(count_reg);
                unique case (op_reg)
                    isu_pkg::OP_CLEAR:
                        status_reg <= isu_pkg::ST_OK;
                    isu_pkg::OP_ADD:
                        if (no_room_1)
                            status_reg <= isu_pkg::ST_FULL;
                    isu_pkg::OP_READ:
                        if (bad_a)
                            status_reg <= isu_pkg::ST_UNWRITTEN;
                    default:
                    begin
                        if (bad_a || bad_b || bad_c)
                            status_reg <= isu_pkg::ST_UNWRITTEN;
                        else if (no_room_3)
                            status_reg <= isu_pkg::ST_FULL;
                    end
                endcase
            end
            isu_pkg::B_RD_WAIT:
                {vx_reg, vy_reg, vz_reg} <= rdata_reg;
            isu_pkg::B_NORM_ADD:
            begin
                if (norm_done)
                begin
                    if (norm_zero)
                        status_reg <= isu_pkg::ST_ZERO;
                    {vx_reg, vy_reg, vz_reg} <= {nr_x, nr_y, nr_z};
                end
            end
            isu_pkg::B_CORNER:
            begin
                corner_reg[cnt_reg] <= rdata_reg;
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 1'b1;
            end
            isu_pkg::B_MID_WAIT:
            begin
                if (norm_done)
                begin
                    mid_reg[cnt_reg] <= {nr_x, nr_y, nr_z};
                    if (norm_zero)
                    begin
                        status_reg <= isu_pkg::ST_ZERO;
                        cnt_reg    <= '0;
                    end
                    else
                        cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 1'b1;
                end
            end
            isu_pkg::B_WRITE:
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 1'b1;
            isu_pkg::B_EMIT:
                if (!res_full)
                    cnt_reg <= cnt_reg + 1'b1;
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/core/icosphere_subdivider_unit.sv
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+-------------------
// input    | operation coord_x/y/z index_a/b/c             | push, full
// result   | tri_first/second/third vertex_x/y/z new_index | empty, pop
//          | status last                                   |
// Add: squares, then one root bit and one quotient bit per cycle in the normalizer.
// Subdivide: up to three normalizer runs plus corner reads and writes; the four result
// words are then pushed in order, each as the result queue has room.
// 4-word input and result queues let each side stall alone; a full result queue holds the back.
// Reset clears the vertex count, the queue pointers and the control states; the store itself is not cleared.
module icosphere_subdivider_unit #(
    parameter int MAX_VERTICES = isu_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = isu_pkg::COORD_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                operation,
    input  logic [COORD_WIDTH-1:0]    coord_x,
    input  logic [COORD_WIDTH-1:0]    coord_y,
    input  logic [COORD_WIDTH-1:0]    coord_z,
    input  logic [isu_pkg::IDX_W-1:0] index_a,
    input  logic [isu_pkg::IDX_W-1:0] index_b,
    input  logic [isu_pkg::IDX_W-1:0] index_c,
    output logic                      empty,
    input  logic                      pop,
    output logic [isu_pkg::IDX_W-1:0] tri_first,
    output logic [isu_pkg::IDX_W-1:0] tri_second,
    output logic [isu_pkg::IDX_W-1:0] tri_third,
    output logic [COORD_WIDTH-1:0]    vertex_x,
    output logic [COORD_WIDTH-1:0]    vertex_y,
    output logic [COORD_WIDTH-1:0]    vertex_z,
    output logic [isu_pkg::IDX_W-1:0] new_index,
    output logic [1:0]                status,
    output logic                      last
);

    localparam int IW = isu_pkg::IDX_W;
    localparam int PW = 3*COORD_WIDTH + 3*IW;
    localparam int RW = 6*IW/2 + 3*COORD_WIDTH + IW + 3;

    logic           item_valid;
    isu_pkg::op_t   item_op;
    logic [PW-1:0]  item_data;
    logic           item_pop;
    logic           res_full;
    logic           res_push;
    logic [RW-1:0]  res_wdata;
    logic [RW-1:0]  res_rdata;

    isu_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .index_a    (index_a),
        .index_b    (index_b),
        .index_c    (index_c),
        .item_valid (item_valid),
        .item_op    (item_op),
        .item_data  (item_data),
        .item_pop   (item_pop)
    );

    isu_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item_op),
        .item_data  (item_data),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_wdata)
    );

    isu_outq #(
        .WIDTH(RW)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res_rdata)
    );

    assign {tri_first, tri_second, tri_third, vertex_x, vertex_y, vertex_z,
            new_index, status, last} = res_rdata;

endmodule
